// ===== rtl/rpb_pkg.sv =====
package rpb_pkg;

    // Number of root bits produced by the square-root chain (one per cell).
    localparam int SQRT_STEPS = 32;
    // Default number of CORDIC iterations.
    localparam int CORDIC_STAGES_DEF = 16;
    // Width of an angle operand before normalization.
    localparam int PW = 34;
    // Width of a normalized operand: larger magnitude in [2^39, 2^40).
    localparam int NW = 41;
    // Width of a CORDIC vector component, with room for the gain.
    localparam int CW = 43;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          ang;
        logic                 zero;
    } vec_t;

    typedef struct packed {
        logic [63:0]        rem;
        logic [63:0]        root;
        vec_t               los;
        vec_t               yaw;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } cell_data_t;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        begin
            unique case (i)
                0: r = 32'd536870912;
                1: r = 32'd316933406;
                2: r = 32'd167458907;
                3: r = 32'd85004756;
                4: r = 32'd42667331;
                5: r = 32'd21354465;
                6: r = 32'd10679838;
                7: r = 32'd5340245;
                8: r = 32'd2670163;
                9: r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                24: r = 32'd41;
                25: r = 32'd20;
                26: r = 32'd10;
                27: r = 32'd5;
                28: r = 32'd3;
                29: r = 32'd1;
                30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/rpb_prep.sv =====
module rpb_prep
    import rpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [PW-1:0] in_x,
    input  logic signed [PW-1:0] in_y,
    output vec_t                 out_vec
);

    logic signed [NW-1:0] p1_x_reg, p1_y_reg, p2_x_reg, p2_y_reg;
    logic [39:0]          p1_m_reg, p2_m_reg;
    logic                 p1_zero_reg, p2_zero_reg;
    vec_t                 out_reg;

    logic signed [NW-1:0] p1_x_next, p1_y_next, p2_x_next, p2_y_next;
    logic [39:0]          p1_m_next, p2_m_next;
    logic [PW-1:0]        ax, ay, am;
    vec_t                 out_next;
    logic signed [NW-1:0] x3, y3;
    logic [39:0]          m3;

    // Larger magnitude, then a fixed pre-scale that brings it below 2^40.
    always_comb begin
        ax = in_x[PW-1] ? PW'(-in_x) : PW'(in_x);
        ay = in_y[PW-1] ? PW'(-in_y) : PW'(in_y);
        am = (ax > ay) ? ax : ay;
        p1_x_next = NW'(in_x) <<< 6;
        p1_y_next = NW'(in_y) <<< 6;
        p1_m_next = 40'(am) << 6;
    end

    // Coarse normalizing shifts.
    always_comb begin
        p2_x_next = p1_x_reg;
        p2_y_next = p1_y_reg;
        p2_m_next = p1_m_reg;
        if (p2_m_next[39:8] == '0) begin
            p2_m_next = p2_m_next << 32;
            p2_x_next = p2_x_next <<< 32;
            p2_y_next = p2_y_next <<< 32;
        end
        if (p2_m_next[39:24] == '0) begin
            p2_m_next = p2_m_next << 16;
            p2_x_next = p2_x_next <<< 16;
            p2_y_next = p2_y_next <<< 16;
        end
        if (p2_m_next[39:32] == '0) begin
            p2_m_next = p2_m_next << 8;
            p2_x_next = p2_x_next <<< 8;
            p2_y_next = p2_y_next <<< 8;
        end
    end

    // Fine shifts, then fold the left half plane onto the right one.
    always_comb begin
        x3 = p2_x_reg;
        y3 = p2_y_reg;
        m3 = p2_m_reg;
        if (m3[39:36] == '0) begin
            m3 = m3 << 4;
            x3 = x3 <<< 4;
            y3 = y3 <<< 4;
        end
        if (m3[39:38] == '0) begin
            m3 = m3 << 2;
            x3 = x3 <<< 2;
            y3 = y3 <<< 2;
        end
        if (!m3[39]) begin
            x3 = x3 <<< 1;
            y3 = y3 <<< 1;
        end
        out_next.zero = p2_zero_reg;
        if (x3 < 0) begin
            out_next.x   = -CW'(x3);
            out_next.y   = -CW'(y3);
            out_next.ang = 32'h8000_0000;
        end else begin
            out_next.x   = CW'(x3);
            out_next.y   = CW'(y3);
            out_next.ang = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_x_reg    <= p1_x_next;
            p1_y_reg    <= p1_y_next;
            p1_m_reg    <= p1_m_next;
            p1_zero_reg <= (am == '0);
            p2_x_reg    <= p2_x_next;
            p2_y_reg    <= p2_y_next;
            p2_m_reg    <= p2_m_next;
            p2_zero_reg <= p1_zero_reg;
            out_reg     <= out_next;
        end
    end

    assign out_vec = out_reg;

endmodule

// ===== rtl/rpb_cell.sv =====
module rpb_cell
    import rpb_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  cell_data_t in_data,
    output logic       out_valid,
    output cell_data_t out_data
);

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * IDX);
    localparam logic [31:0] ATAN   = atan_turn(IDX);
    localparam bit          DO_ROT = (IDX < CORDIC_STAGES);

    logic       valid_reg;
    cell_data_t data_reg, data_next;
    logic [63:0] trial;

    function automatic vec_t rotate(input vec_t v);
        vec_t r;
        logic signed [CW-1:0] xs, ys;
        begin
            r  = v;
            xs = v.x >>> IDX;
            ys = v.y >>> IDX;
            if (v.y > 0) begin
                r.x   = v.x + ys;
                r.y   = v.y - xs;
                r.ang = v.ang + ATAN;
            end else begin
                r.x   = v.x - ys;
                r.y   = v.y + xs;
                r.ang = v.ang - ATAN;
            end
            return r;
        end
    endfunction

    always_comb begin
        data_next = in_data;
        // One bit of the integer square root.
        trial = in_data.root + SQ_BIT;
        if (in_data.rem >= trial) begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + SQ_BIT;
        end else begin
            data_next.root = in_data.root >> 1;
        end
        // One CORDIC iteration on each vector, in the first CORDIC_STAGES cells only.
        if (DO_ROT) begin
            data_next.los = rotate(in_data.los);
            data_next.yaw = rotate(in_data.yaw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/relative_polar_bearing.sv =====
// Relative polar bearing of a leader seen from a follower.
//
// Input channel (s_valid/s_ready): one item holds the leader and follower
// positions in Q16.16 and the follower's orientation quaternion in Q1.14.
// Result channel (m_valid/m_ready): one item per input item, in order, with
// the saturated offset, the range, the line-of-sight angle, the follower
// heading from the quaternion and their difference, angles in 1/65536 turn.
//
// The block is one pipeline that takes an item every cycle unless the
// receiver stalls. Its stages are offset and product formation, squares
// and sums, operand normalization, a chain of 32 cells and the output
// register. Each cell produces one bit of the integer square root and,
// for the first CORDIC_STAGES cells, one CORDIC iteration for each of the
// two angles; the chain length is set by the 32 root bits.
//
// Reset clears all valid bits; no result item is pending afterward. When
// the receiver stalls a waiting result, the whole pipeline holds and
// s_ready drops in that same cycle; a stage only advances when the output
// register is empty or being emptied.
module relative_polar_bearing
    import rpb_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_leader_x,
    input  logic signed [31:0] s_leader_y,
    input  logic signed [31:0] s_follower_x,
    input  logic signed [31:0] s_follower_y,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_offset_x,
    output logic signed [31:0] m_offset_y,
    output logic [31:0]        m_range,
    output logic [15:0]        m_sight_angle,
    output logic [15:0]        m_heading,
    output logic signed [16:0] m_relative_angle
);

    logic en;

    // Valid bits of the five front stages.
    logic [4:0] front_valid_reg;

    // Stage 1: saturated offsets and quaternion products.
    logic signed [31:0] dx1_reg, dy1_reg, dx1_next, dy1_next;
    logic signed [31:0] pxy_reg, pwz_reg, pww_reg, pxx_reg, pyy_reg, pzz_reg;
    logic signed [32:0] diff_x, diff_y;

    // Stage 2: squares and quaternion sums.
    logic signed [31:0] dx2_reg, dy2_reg;
    logic signed [63:0] sqx_reg, sqy_reg;
    logic signed [PW-1:0] num2_reg, den2_reg;

    // Stages 3 to 5: delayed offsets and squared range.
    logic signed [31:0] dx3_reg, dy3_reg, dx4_reg, dy4_reg, dx5_reg, dy5_reg;
    logic [63:0]        sq3_reg, sq4_reg, sq5_reg;

    vec_t los_vec, yaw_vec;

    logic       cell_valid [0:SQRT_STEPS];
    cell_data_t cell_data  [0:SQRT_STEPS];

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] out_dx_reg, out_dy_reg;
    logic [31:0]        out_range_reg;
    logic [15:0]        out_los_reg, out_yaw_reg, los_next, yaw_next;
    logic signed [16:0] out_rel_reg;
    cell_data_t         last;
    logic [31:0]        los_round, yaw_round;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        diff_x = 33'(s_leader_x) - 33'(s_follower_x);
        diff_y = 33'(s_leader_y) - 33'(s_follower_y);
        if (diff_x[32] != diff_x[31]) begin
            dx1_next = diff_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            dx1_next = diff_x[31:0];
        end
        if (diff_y[32] != diff_y[31]) begin
            dy1_next = diff_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            dy1_next = diff_y[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= '0;
        end else if (en) begin
            front_valid_reg <= {front_valid_reg[3:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            pxy_reg  <= 32'(s_quat_x) * 32'(s_quat_y);
            pwz_reg  <= 32'(s_quat_w) * 32'(s_quat_z);
            pww_reg  <= 32'(s_quat_w) * 32'(s_quat_w);
            pxx_reg  <= 32'(s_quat_x) * 32'(s_quat_x);
            pyy_reg  <= 32'(s_quat_y) * 32'(s_quat_y);
            pzz_reg  <= 32'(s_quat_z) * 32'(s_quat_z);

            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            sqx_reg  <= 64'(dx1_reg) * 64'(dx1_reg);
            sqy_reg  <= 64'(dy1_reg) * 64'(dy1_reg);
            num2_reg <= (PW'(pxy_reg) + PW'(pwz_reg)) <<< 1;
            den2_reg <= PW'(pww_reg) + PW'(pxx_reg) - PW'(pyy_reg) - PW'(pzz_reg);

            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            sq3_reg  <= 64'(sqx_reg) + 64'(sqy_reg);
            dx4_reg  <= dx3_reg;
            dy4_reg  <= dy3_reg;
            sq4_reg  <= sq3_reg;
            dx5_reg  <= dx4_reg;
            dy5_reg  <= dy4_reg;
            sq5_reg  <= sq4_reg;
        end
    end

    // Line of sight: atan2(dy, dx). Heading: atan2(num, den).
    rpb_prep u_prep_los (
        .aclk    (aclk),
        .en      (en),
        .in_x    (PW'(dx2_reg)),
        .in_y    (PW'(dy2_reg)),
        .out_vec (los_vec)
    );

    rpb_prep u_prep_yaw (
        .aclk    (aclk),
        .en      (en),
        .in_x    (den2_reg),
        .in_y    (num2_reg),
        .out_vec (yaw_vec)
    );

    always_comb begin
        cell_valid[0]     = front_valid_reg[4];
        cell_data[0].rem  = sq5_reg;
        cell_data[0].root = '0;
        cell_data[0].los  = los_vec;
        cell_data[0].yaw  = yaw_vec;
        cell_data[0].dx   = dx5_reg;
        cell_data[0].dy   = dy5_reg;
    end

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
        rpb_cell #(
            .IDX           (i),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // Round the turn angles half up to 16 bits; a zero vector reads 0.
    always_comb begin
        last      = cell_data[SQRT_STEPS];
        los_round = last.los.ang + 32'h0000_8000;
        yaw_round = last.yaw.ang + 32'h0000_8000;
        los_next  = last.los.zero ? 16'd0 : los_round[31:16];
        yaw_next  = last.yaw.zero ? 16'd0 : yaw_round[31:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= cell_valid[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_dx_reg    <= last.dx;
            out_dy_reg    <= last.dy;
            // The root of a sum of two int32 squares stays below 2^32.
            out_range_reg <= last.root[31:0];
            out_los_reg   <= los_next;
            out_yaw_reg   <= yaw_next;
            out_rel_reg   <= 17'(los_next) - 17'(yaw_next);
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_offset_x       = out_dx_reg;
    assign m_offset_y       = out_dy_reg;
    assign m_range          = out_range_reg;
    assign m_sight_angle    = out_los_reg;
    assign m_heading        = out_yaw_reg;
    assign m_relative_angle = out_rel_reg;

    // The relative angle is always the difference of the two angles shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_relative_angle == (17'(m_sight_angle) - 17'(m_heading))))
        else $error("relative angle does not match sight angle minus heading");

    // Leaving reset, no result item is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A stalled result freezes the front of the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(front_valid_reg))
        else $error("pipeline moved while the output was stalled");

    // Input is taken exactly when the pipeline advances.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> front_valid_reg[0])
        else $error("accepted item lost at the first stage");

endmodule

// ===== bench/tb_relative_polar_bearing.sv =====
module tb_relative_polar_bearing;
    import rpb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    // One pose pair as it is offered on the input channel. The drain flag asks
    // the driver to hold this item back until every earlier result has arrived.
    typedef struct {
        logic signed [31:0] leader_x;
        logic signed [31:0] leader_y;
        logic signed [31:0] follower_x;
        logic signed [31:0] follower_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        bit                 drain;
    } pose_pair_t;

    // One polar result item as the block should present it.
    typedef struct {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [31:0]        range;
        logic [15:0]        sight_angle;
        logic [15:0]        heading;
        logic signed [16:0] relative_angle;
    } polar_result_t;

    // Arctangent of 2^-i in units of 2^-32 turn, used by the angle predictor.
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
        32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
        32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
        32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_leader_x = '0;
    logic signed [31:0] s_leader_y = '0;
    logic signed [31:0] s_follower_x = '0;
    logic signed [31:0] s_follower_y = '0;
    logic signed [15:0] s_quat_w = '0;
    logic signed [15:0] s_quat_x = '0;
    logic signed [15:0] s_quat_y = '0;
    logic signed [15:0] s_quat_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_offset_x;
    logic signed [31:0] m_offset_y;
    logic [31:0]        m_range;
    logic [15:0]        m_sight_angle;
    logic [15:0]        m_heading;
    logic signed [16:0] m_relative_angle;

    pose_pair_t    pending_poses[$];
    polar_result_t expected_polar[$];

    int  error_count = 0;
    int  results_seen = 0;
    int  poses_sent = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  ready_mode = 0;
    int  ready_mode_left = 0;

    relative_polar_bearing i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_leader_x       (s_leader_x),
        .s_leader_y       (s_leader_y),
        .s_follower_x     (s_follower_x),
        .s_follower_y     (s_follower_y),
        .s_quat_w         (s_quat_w),
        .s_quat_x         (s_quat_x),
        .s_quat_y         (s_quat_y),
        .s_quat_z         (s_quat_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_offset_x       (m_offset_x),
        .m_offset_y       (m_offset_y),
        .m_range          (m_range),
        .m_sight_angle    (m_sight_angle),
        .m_heading        (m_heading),
        .m_relative_angle (m_relative_angle)
    );

    always #5 aclk = ~aclk;

    // Clamp a 64-bit difference to the signed 32-bit range.
    function automatic longint clamp_int32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // atan2(y, x) as a 16-bit fraction of a turn. The pair is first scaled by
    // a power of two so that its larger magnitude sits in [2^39, 2^40), then
    // the vectoring iterations run with floor shifts and the 32-bit angle is
    // rounded half up. A zero vector gives angle zero.
    function automatic logic [15:0] turn_atan2(input longint x, input longint y);
        longint      xv;
        longint      yv;
        longint      xs;
        longint      ys;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] mag;
        logic [31:0] ang;
        logic [31:0] rounded;
        int          bits;
        ax = (x < 0) ? 64'(-x) : 64'(x);
        ay = (y < 0) ? 64'(-y) : 64'(y);
        mag = (ax > ay) ? ax : ay;
        if (mag == 0) return 16'd0;
        bits = 0;
        while (bits < 64 && (mag >> bits) != 0) bits++;
        xv = x;
        yv = y;
        if (bits < 40) begin
            xv = x <<< (40 - bits);
            yv = y <<< (40 - bits);
        end
        ang = 32'd0;
        // Fold the left half plane onto the right by a half-turn rotation.
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0) begin
                xv = xv + ys;
                yv = yv - xs;
                ang = ang + ATAN_STEP[i];
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                ang = ang - ATAN_STEP[i];
            end
        end
        rounded = ang + 32'h0000_8000;
        return rounded[31:16];
    endfunction

    // Floor of the square root of a 64-bit unsigned value, bit by bit.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        rem = n;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Works out the polar result that one pose pair must produce.
    function automatic polar_result_t predict_polar(input pose_pair_t p);
        polar_result_t r;
        longint        dx;
        longint        dy;
        longint        qw;
        longint        qx;
        longint        qy;
        longint        qz;
        longint        num;
        longint        den;
        logic [63:0]   sq;
        logic [63:0]   root;
        logic [15:0]   los;
        logic [15:0]   yaw;
        longint        diff;
        dx = clamp_int32(longint'(p.leader_x) - longint'(p.follower_x));
        dy = clamp_int32(longint'(p.leader_y) - longint'(p.follower_y));
        sq = 64'(dx * dx) + 64'(dy * dy);
        root = floor_sqrt(sq);
        qw = p.quat_w;
        qx = p.quat_x;
        qy = p.quat_y;
        qz = p.quat_z;
        num = 2 * (qx * qy + qw * qz);
        den = qw * qw + qx * qx - qy * qy - qz * qz;
        los = turn_atan2(dx, dy);
        yaw = turn_atan2(den, num);
        diff = longint'(los) - longint'(yaw);
        r.offset_x = dx[31:0];
        r.offset_y = dy[31:0];
        r.range = (root > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
        r.sight_angle = los;
        r.heading = yaw;
        r.relative_angle = diff[16:0];
        return r;
    endfunction

    function automatic pose_pair_t make_pose(
        input logic [31:0] lx, input logic [31:0] ly,
        input logic [31:0] fx, input logic [31:0] fy,
        input logic [15:0] qw, input logic [15:0] qx,
        input logic [15:0] qy, input logic [15:0] qz);
        pose_pair_t p;
        p.leader_x = lx;
        p.leader_y = ly;
        p.follower_x = fx;
        p.follower_y = fy;
        p.quat_w = qw;
        p.quat_x = qx;
        p.quat_y = qy;
        p.quat_z = qz;
        p.drain = 1'b0;
        return p;
    endfunction

    // Appends one pose pair to the stimulus list.
    task automatic queue_pose(input pose_pair_t p);
        pending_poses = {pending_poses, p};
    endtask

    // Random pose pair. Most pairs are close together, as real formations
    // are, but full-range positions and quaternions appear often enough that
    // every input bit toggles and the offsets saturate now and then.
    function automatic pose_pair_t random_pose();
        pose_pair_t  p;
        int          sel;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        p.leader_x = $urandom;
        p.leader_y = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            p.follower_x = $urandom;
            p.follower_y = $urandom;
        end else if (sel < 9) begin
            delta_x = $urandom_range(0, 32'h00FF_FFFF);
            delta_y = $urandom_range(0, 32'h00FF_FFFF);
            p.follower_x = p.leader_x - delta_x + 32'h0080_0000;
            p.follower_y = p.leader_y - delta_y + 32'h0080_0000;
        end else begin
            // Coincident or axis-aligned positions.
            p.follower_x = p.leader_x;
            p.follower_y = $urandom_range(0, 1) ? p.leader_y : $urandom;
        end
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            p.quat_w = $urandom;
            p.quat_x = $urandom;
            p.quat_y = $urandom;
            p.quat_z = $urandom;
        end else if (sel < 9) begin
            p.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
        end else begin
            // Pure yaw rotations and the occasional empty quaternion.
            p.quat_w = $urandom_range(0, 3) == 0 ? 16'sd0 : 16'($urandom);
            p.quat_x = 16'sd0;
            p.quat_y = 16'sd0;
            p.quat_z = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
        end
        p.drain = 1'b0;
        return p;
    endfunction

    // The stimulus list is built at time zero, before reset is released.
    initial begin
        pose_pair_t p;
        // Coincident positions and an all-zero quaternion give zero angles.
        queue_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0));
        queue_pose(make_pose(32'h0001_0000, 0, 0, 0, 16384, 0, 0, 0));
        // Leader straight down the negative x axis, half a turn.
        queue_pose(make_pose(32'hFFFF_0000, 0, 0, 0, 16384, 0, 0, 0));
        queue_pose(make_pose(0, 32'h0001_0000, 0, 0, 0, 0, 0, 16384));
        queue_pose(make_pose(0, 32'hFFFF_0000, 0, 0, 16'hC000, 0, 0, 0));
        // Offsets that saturate in both directions.
        queue_pose(make_pose(32'h7FFF_FFFF, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF,
                             16384, 16384, 16384, 16384));
        queue_pose(make_pose(32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             16'hC000, 16'hC000, 16'hC000, 16'hC000));
        queue_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h8000_0000,
                             0, 16384, 0, 0));
        // Quaternions outside the unit range, taken as given.
        queue_pose(make_pose(1, 1, 0, 0, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h7FFF));
        queue_pose(make_pose(1, 0, 0, 1, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000));
        queue_pose(make_pose(32'hFFFF_FFFF, 1, 0, 0, 16'h8000, 0,
                             16'h7FFF, 0));
        // Yaw of a quarter turn and three quarters, and a flipped body.
        queue_pose(make_pose(5, 7, 3, 9, 11585, 0, 0, 11585));
        queue_pose(make_pose(5, 7, 3, 9, 11585, 0, 0, 16'(-11585)));
        queue_pose(make_pose(5, 7, 3, 9, 0, 16384, 0, 0));
        queue_pose(make_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                             0, 0, 16384, 0));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            p = random_pose();
            // Now and then the sender waits for the pipeline to drain.
            p.drain = (i % 150 == 75);
            queue_pose(p);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: offers pending items in bursts of random length separated by
    // random gaps. A new item is only put up when the channel is free, so a
    // valid item is never withdrawn or changed before it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_polar = {expected_polar, predict_polar(pending_poses[0])};
                pending_poses.pop_front();
                poses_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_poses.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_poses[0].drain &&
                             (expected_polar.size() != 0 || (s_valid && s_ready))) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_leader_x <= pending_poses[0].leader_x;
                    s_leader_y <= pending_poses[0].leader_y;
                    s_follower_x <= pending_poses[0].follower_x;
                    s_follower_y <= pending_poses[0].follower_y;
                    s_quat_w <= pending_poses[0].quat_w;
                    s_quat_x <= pending_poses[0].quat_x;
                    s_quat_y <= pending_poses[0].quat_y;
                    s_quat_z <= pending_poses[0].quat_z;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Long unbroken bursts are mixed at random with short choppy ones.
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 90)
                                                               : $urandom_range(0, 6);
                        gap_left = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // Monitor: the receiver switches between always ready, random stalls and
    // mostly stalled, and checks each accepted result against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        polar_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_polar.size() == 0) begin
                    $error("result item arrived with no expectation pending");
                    error_count++;
                end else begin
                    want = expected_polar.pop_front();
                    if (m_offset_x !== want.offset_x) begin
                        $error("offset_x expected %0d actual %0d", want.offset_x, m_offset_x);
                        error_count++;
                    end
                    if (m_offset_y !== want.offset_y) begin
                        $error("offset_y expected %0d actual %0d", want.offset_y, m_offset_y);
                        error_count++;
                    end
                    if (m_range !== want.range) begin
                        $error("range expected %0d actual %0d", want.range, m_range);
                        error_count++;
                    end
                    if (m_sight_angle !== want.sight_angle) begin
                        $error("sight_angle expected %0d actual %0d",
                               want.sight_angle, m_sight_angle);
                        error_count++;
                    end
                    if (m_heading !== want.heading) begin
                        $error("heading expected %0d actual %0d", want.heading, m_heading);
                        error_count++;
                    end
                    if (m_relative_angle !== want.relative_angle) begin
                        $error("relative_angle expected %0d actual %0d",
                               want.relative_angle, m_relative_angle);
                        error_count++;
                    end
                end
            end
            if (ready_mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                ready_mode_left = $urandom_range(20, 200);
            end else begin
                ready_mode_left--;
            end
            case (ready_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= $urandom_range(0, 1);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 4) == 0);
                end
            endcase
        end
    end

    // Watchdog against a hung pipeline.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // End of run: once every item is in and every result is out, let the
    // pipeline settle for longer than its latency to catch stray results.
    initial begin
        wait (aresetn);
        wait (pending_poses.size() == 0 && !s_valid && expected_polar.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_polar.size() != 0) begin
            $error("%0d expected result items never arrived", expected_polar.size());
            error_count++;
        end
        $display("Sent %0d pose pairs (directed extremes, saturation, zero vectors, random)",
                 poses_sent);
        $display("Checked %0d polar results under bursty input and receiver stalls",
                 results_seen);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
